/* hdl/scfe_pkg.sv */
// Package: transaction types, frame constants and the CRC-16/Modbus byte update.
`default_nettype none
package scfe_pkg;

  localparam int unsigned FrameBytes = 10;
  localparam int unsigned DataBytes  = 8;
  localparam int unsigned PosWidth   = 4;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [PosWidth-1:0] PosCrcLo = PosWidth'(DataBytes);
  localparam logic [PosWidth-1:0] PosLast  = PosWidth'(FrameBytes - 1);

  // channel_zero sits in the low bits so that byte k of the flat vector is frame byte k
  typedef struct packed {
    logic signed [15:0] channel_three;
    logic signed [15:0] channel_two;
    logic signed [15:0] channel_one;
    logic signed [15:0] channel_zero;
  } in_item_t;

  typedef struct packed {
    logic [7:0]          frame_byte;
    logic [PosWidth-1:0] byte_position;
    logic                last_byte;
  } out_item_t;

  // one byte through the reflected CRC, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* hdl/scope_frame_crc16_encoder.sv */
// Top level: four-channel scope frame encoder with CRC-16/Modbus trailer.
// A taken set is queued, loaded into item_q once the back end is free, and each byte is registered.
// Throughput: one frame byte per cycle while a frame is out, set by the byte serializer.
// busy rises only when the two-entry queue is full; frames stream back to back while sets wait.
// The receiver cannot stall: each byte is on result_o for one cycle with result_strobe_o high.
// Reset (rst_ni low, asynchronous) empties the queue and idles the serializer; no data state.
`default_nettype none
module scope_frame_crc16_encoder (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  input  wire scfe_pkg::in_item_t data_i,
  output logic                    busy,
  output logic                    result_strobe_o,
  output scfe_pkg::out_item_t     result_o
);
  import scfe_pkg::*;

  // queue hand-off between front and back
  logic     pop;
  logic     avail;
  in_item_t head;

  // front end: takes a transaction when start is high and busy is low
  scfe_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .data_i  (data_i),
    .busy    (busy),
    .pop_i   (pop),
    .avail_o (avail),
    .head_o  (head)
  );

  // back end: pulls the next set on the last byte of the current frame,
  // so consecutive frames leave with no idle cycle between them
  scfe_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .avail_i         (avail),
    .head_i          (head),
    .pop_o           (pop),
    .result_strobe_o (result_strobe_o),
    .result_o        (result_o)
  );

endmodule
`default_nettype wire

/* hdl/scfe_front.sv */
// Front end: accepts sample sets and holds them in a two-entry queue for the back end.
`default_nettype none
module scfe_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire scfe_pkg::in_item_t data_i,
  output logic                   busy,
  input  wire logic              pop_i,
  output logic                   avail_o,
  output scfe_pkg::in_item_t     head_o
);
  import scfe_pkg::*;

  in_item_t    mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        push, pop;

  assign busy    = (count_q == 2'd2);
  assign avail_o = (count_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];
  assign push    = start && !busy;
  assign pop     = pop_i && avail_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue count out of range");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

/* hdl/scfe_back.sv */
// Back end: serializes one frame a byte per cycle and folds the data bytes into the CRC.
`default_nettype none
module scfe_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               avail_i,
  input  wire scfe_pkg::in_item_t head_i,
  output logic                    pop_o,
  output logic                    result_strobe_o,
  output scfe_pkg::out_item_t     result_o
);
  import scfe_pkg::*;

  logic                active_q, active_d;
  logic [PosWidth-1:0] pos_q, pos_d;
  logic [15:0]         crc_q, crc_d;
  in_item_t            item_q;
  logic [63:0]         flat;
  logic [7:0]          cur_byte;
  logic                at_last;
  logic                strobe_q;
  out_item_t           result_q;

  assign flat    = item_q;
  assign at_last = (pos_q == PosLast);
  assign pop_o   = avail_i && (!active_q || at_last);

  always_comb begin
    if (pos_q == PosCrcLo) begin
      cur_byte = crc_q[7:0];
    end else if (at_last) begin
      cur_byte = crc_q[15:8];
    end else begin
      cur_byte = flat[8*pos_q[2:0] +: 8];
    end
  end

  always_comb begin
    active_d = active_q;
    pos_d    = pos_q;
    crc_d    = crc_q;
    if (active_q) begin
      pos_d = pos_q + 1'b1;
      if (pos_q < PosCrcLo) begin
        crc_d = crc_byte(crc_q, cur_byte);
      end
      if (at_last) begin
        active_d = 1'b0;
      end
    end
    if (pop_o) begin
      active_d = 1'b1;
      pos_d    = '0;
      crc_d    = CrcInit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pos_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      active_q <= active_d;
      pos_q    <= pos_d;
      strobe_q <= active_q;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
    if (pop_o) begin
      item_q <= head_i;
    end
    result_q.frame_byte    <= cur_byte;
    result_q.byte_position <= pos_q;
    result_q.last_byte     <= at_last;
  end

  assign result_strobe_o = strobe_q;
  assign result_o        = result_q;

  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q && !at_last) |=> (active_q && pos_q == $past(pos_q) + 1'b1))
    else $error("byte position skipped");
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (pos_q <= PosLast)) else $error("byte position beyond frame");
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> (result_o.last_byte == (result_o.byte_position == PosLast)))
    else $error("last byte flag misplaced");

endmodule
`default_nettype wire

/* bench/scope_frame_crc16_encoder_check.sv */
// Checker: predicts each scope frame with CRC-16/Modbus and compares the byte stream.
module scope_frame_crc16_encoder_check (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic                busy_i,
  input  wire scfe_pkg::in_item_t  data_i,
  input  wire logic                strobe_i,
  input  wire scfe_pkg::out_item_t result_i,
  input  wire logic                flush_i,
  output int                       errors_o,
  output int                       pending_o,
  output int                       checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import scfe_pkg::*;

  localparam logic [15:0] ModbusSeed = 16'hFFFF;
  localparam logic [15:0] ModbusPoly = 16'hA001;

  out_item_t bytes_due[$];
  out_item_t frame[FrameBytes];
  out_item_t want;

  initial begin
    errors_o  = 0;
    pending_o = 0;
    checked_o = 0;
  end

  // bit-serial reflected update: feedback is crc lsb xor data bit, data lsb first
  function automatic logic [15:0] modbus_crc_step(input logic [15:0] crc,
                                                  input logic [7:0]  b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c  = c >> 1;
      if (fb) begin
        c = c ^ ModbusPoly;
      end
    end
    return c;
  endfunction

  // channel_zero occupies the low bits, so byte k of the flat vector is frame byte k
  task automatic build_frame(input in_item_t s, output out_item_t f[FrameBytes]);
    logic [63:0] flat;
    logic [15:0] crc;
    logic [7:0]  b;
    flat = s;
    crc  = ModbusSeed;
    for (int k = 0; k < FrameBytes; k++) begin
      if (k < DataBytes) begin
        b   = flat[8*k +: 8];
        crc = modbus_crc_step(crc, b);
      end else if (k == DataBytes) begin
        b = crc[7:0];
      end else begin
        b = crc[15:8];
      end
      f[k].frame_byte    = b;
      f[k].byte_position = PosWidth'(k);
      f[k].last_byte     = (k == FrameBytes - 1);
    end
  endtask

  task automatic flag_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    errors_o++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // retire before predicting: a byte can never belong to a set taken at the same edge
      if (strobe_i) begin
        if (bytes_due.size() == 0) begin
          flag_mismatch($sformatf("byte %02h at position %0d with no frame pending",
                                  result_i.frame_byte, result_i.byte_position));
        end else begin
          want = bytes_due.pop_front();
          if (result_i.frame_byte !== want.frame_byte)
            flag_mismatch($sformatf("frame byte %0d: got %02h want %02h", checked_o,
                                    result_i.frame_byte, want.frame_byte));
          if (result_i.byte_position !== want.byte_position)
            flag_mismatch($sformatf("frame byte %0d: position got %0d want %0d", checked_o,
                                    result_i.byte_position, want.byte_position));
          if (result_i.last_byte !== want.last_byte)
            flag_mismatch($sformatf("frame byte %0d: last flag got %0b want %0b", checked_o,
                                    result_i.last_byte, want.last_byte));
          checked_o++;
        end
      end
      if (start_i && !busy_i) begin
        build_frame(data_i, frame);
        for (int k = 0; k < FrameBytes; k++) begin
          bytes_due.push_back(frame[k]);
        end
      end
      if (flush_i && bytes_due.size() != 0) begin
        flag_mismatch($sformatf("%0d frame bytes never arrived", bytes_due.size()));
      end
      pending_o = bytes_due.size();
    end
  end

endmodule

/* bench/scope_frame_crc16_encoder_test.sv */
// Testbench top: drives sample sets into the scope frame encoder and gives the verdict.
module scope_frame_crc16_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import scfe_pkg::*;

  // cycles with no transaction on either side before the run is declared hung,
  // set well above the longest sender gap and the time a full queue takes to drain
  localparam int IdleLimit   = 2000;
  localparam int RandomSets  = 400;
  // extra cycles after the last expected byte, to catch any stray byte
  localparam int DrainCycles = 8;

  logic      clk;
  logic      rst_n    = 1'b0;
  logic      start    = 1'b0;
  in_item_t  set_d    = '0;
  logic      busy;
  logic      strobe;
  out_item_t result;
  logic      flush    = 1'b0;

  int        errors;
  int        pending;
  int        checked;
  int        sets_sent = 0;
  int        directed_sets;
  int        idle_cycles = 0;

  scope_frame_crc16_encoder i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start           (start),
    .data_i          (set_d),
    .busy            (busy),
    .result_strobe_o (strobe),
    .result_o        (result)
  );

  scope_frame_crc16_encoder_check i_check (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .start_i   (start),
    .busy_i    (busy),
    .data_i    (set_d),
    .strobe_i  (strobe),
    .result_i  (result),
    .flush_i   (flush),
    .errors_o  (errors),
    .pending_o (pending),
    .checked_o (checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: any accepted transaction, in or out, re-arms it.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || strobe) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("[%0t] watchdog: no transaction for %0d cycles", $time, IdleLimit);
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic in_item_t set_of(input logic [15:0] c0, input logic [15:0] c1,
                                      input logic [15:0] c2, input logic [15:0] c3);
    in_item_t s;
    s.channel_zero  = c0;
    s.channel_one   = c1;
    s.channel_two   = c2;
    s.channel_three = c3;
    return s;
  endfunction

  // Mostly uniform, with a share of sign/rail corners so both extremes recur in the CRC.
  function automatic logic [15:0] random_channel();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return $urandom_range(0, 1) ? 16'h0000 : 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_set();
    return set_of(random_channel(), random_channel(), random_channel(), random_channel());
  endfunction

  // Called at a rising edge. Holds start until the transaction is taken: busy is
  // looked at on the falling edge, where it is stable, so the next rising edge accepts.
  task automatic send_set(input in_item_t s);
    start <= 1'b1;
    set_d <= s;
    do @(negedge clk); while (busy);
    @(posedge clk);
    sets_sent++;
  endtask

  // Sender gap after a transaction; start drops and data is scrambled while idle.
  task automatic sender_gap(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      set_d <= in_item_t'({$urandom, $urandom});
      repeat (cycles) @(posedge clk);
    end
  endtask

  function automatic int pick_gap(input int n);
    int r;
    // every hundred sets, a run of thirty streams with no gaps at all
    if (n % 100 < 30) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: rails, sign corners, single set bits at each end, alternating
    // patterns; sent back to back so the two-entry queue fills and busy shows.
    send_set(set_of(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_set(set_of(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_set(set_of(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    send_set(set_of(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_set(set_of(16'h0001, 16'h0000, 16'h0000, 16'h0000));
    send_set(set_of(16'h0000, 16'h0000, 16'h0000, 16'h8000));
    send_set(set_of(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
    send_set(set_of(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
    send_set(set_of(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0));
    // negative and positive full scale side by side: -1, -32768, 32767, 0
    send_set(set_of(16'hFFFF, 16'h8000, 16'h7FFF, 16'h0000));
    send_set(set_of(16'h00FF, 16'hFF00, 16'h00FF, 16'hFF00));
    sender_gap(25);
    // lone set after an idle stretch on the sender side
    send_set(set_of(16'h8001, 16'hFFFE, 16'h0100, 16'h0080));
    sender_gap(3);
    directed_sets = sets_sent;

    for (int n = 0; n < RandomSets; n++) begin
      send_set(random_set());
      sender_gap(pick_gap(n));
    end
    start <= 1'b0;

    // drain: the watchdog covers a frame that never completes
    do @(negedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
    flush <= 1'b1;
    @(posedge clk);
    flush <= 1'b0;
    @(negedge clk);

    $display("Covered %0d sample sets (%0d directed, rest random) with sender gaps of 0-60 cycles",
             sets_sent, directed_sets);
    $display("Checked %0d frame bytes: data order, CRC-16/Modbus trailer, positions, last flag",
             checked);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/scfe_pkg.sv
hdl/scfe_front.sv
hdl/scfe_back.sv
hdl/scope_frame_crc16_encoder.sv
bench/scope_frame_crc16_encoder_check.sv
bench/scope_frame_crc16_encoder_test.sv
